### design/lps_pkg.sv
// Shared widths, codes, control word layout and microprogram of the prime sieve.
package lps_pkg;

  localparam int VALUE_W = 18;
  localparam int COUNT_W = 16;
  localparam int LIMIT_W = 19;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 19'd250010;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam int FIRST_VALUE = 2;

  localparam int MAX_LIMIT_DEF = 262144;
  localparam int PRIME_SLOTS_DEF = 32768;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_RSTCHK    = 4'd1,
    S_CLR_INIT  = 4'd2,
    S_CLR       = 4'd3,
    S_POST_CLR  = 4'd4,
    S_CHECK     = 4'd5,
    S_PRIME     = 4'd6,
    S_WALK      = 4'd7,
    S_MUL       = 4'd8,
    S_CMP       = 4'd9,
    S_MARK      = 4'd10,
    S_MOD       = 4'd11,
    S_DIVCHK    = 4'd12,
    S_FINISH    = 4'd13,
    S_DONE_OUT  = 4'd14
  } lps_step_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_ALWAYS      = 4'd0,
    C_ACCEPT      = 4'd1,
    C_NOT_RESTART = 4'd2,
    C_CLR_LAST    = 4'd3,
    C_NO_ITEM     = 4'd4,
    C_DONE        = 4'd5,
    C_WALK_END    = 4'd6,
    C_PROD_GE     = 4'd7,
    C_MOD_LAST    = 4'd8,
    C_NOT_DIVIDES = 4'd9,
    C_OUT_FREE    = 4'd10
  } lps_cond_t;

  // Datapath operations of one step.
  typedef struct packed {
    logic req_rdy;
    logic clr_init;
    logic clr_wr;
    logic prime_upd;
    logic mul;
    logic mark;
    logic mod_step;
    logic j_inc;
    logic out_res;
    logic out_done;
  } lps_ctrl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic accept;
    logic restart;
    logic clr_last;
    logic item_live;
    logic done;
    logic walk_end;
    logic prod_ge;
    logic mod_last;
    logic divides;
    logic out_free;
  } lps_stat_t;

  typedef struct packed {
    lps_ctrl_t ops;
    lps_cond_t cond;
    logic      stay;
    lps_step_t target;
  } lps_uword_t;

  // Control store. A step jumps to target when its condition holds, otherwise it
  // either waits in place or moves on to the following address.
  function automatic lps_uword_t ucode(lps_step_t s);
    lps_uword_t w;
    w = '0;
    w.cond = C_ALWAYS;
    w.target = S_IDLE;
    case (s)
      S_IDLE: begin
        w.ops.req_rdy = 1'b1;
        w.cond = C_ACCEPT;
        w.stay = 1'b1;
        w.target = S_RSTCHK;
      end
      S_RSTCHK: begin
        w.cond = C_NOT_RESTART;
        w.target = S_CHECK;
      end
      S_CLR_INIT: begin
        w.ops.clr_init = 1'b1;
        w.cond = C_NOT_RESTART;
        w.target = S_CLR;
      end
      S_CLR: begin
        w.ops.clr_wr = 1'b1;
        w.cond = C_CLR_LAST;
        w.stay = 1'b1;
        w.target = S_POST_CLR;
      end
      S_POST_CLR: begin
        w.cond = C_NO_ITEM;
        w.target = S_IDLE;
      end
      S_CHECK: begin
        w.cond = C_DONE;
        w.target = S_DONE_OUT;
      end
      S_PRIME: begin
        w.ops.prime_upd = 1'b1;
        w.cond = C_WALK_END;
        w.target = S_WALK;
      end
      S_WALK: begin
        w.cond = C_WALK_END;
        w.target = S_FINISH;
      end
      S_MUL: begin
        w.ops.mul = 1'b1;
        w.cond = C_ALWAYS;
        w.target = S_CMP;
      end
      S_CMP: begin
        w.cond = C_PROD_GE;
        w.target = S_FINISH;
      end
      S_MARK: begin
        w.ops.mark = 1'b1;
        w.cond = C_ALWAYS;
        w.target = S_MOD;
      end
      S_MOD: begin
        w.ops.mod_step = 1'b1;
        w.cond = C_MOD_LAST;
        w.stay = 1'b1;
        w.target = S_DIVCHK;
      end
      S_DIVCHK: begin
        w.ops.j_inc = 1'b1;
        w.cond = C_NOT_DIVIDES;
        w.target = S_WALK;
      end
      S_FINISH: begin
        w.ops.out_res = 1'b1;
        w.cond = C_OUT_FREE;
        w.stay = 1'b1;
        w.target = S_IDLE;
      end
      S_DONE_OUT: begin
        w.ops.out_done = 1'b1;
        w.cond = C_OUT_FREE;
        w.stay = 1'b1;
        w.target = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### design/lps_req_if.sv
// Request channel: one restart flag per request.
interface lps_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

### design/lps_rsp_if.sv
// Result channel: candidate value, prime flag, running count and done flag.
interface lps_rsp_if import lps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               is_prime;
  logic [COUNT_W-1:0] prime_count;
  logic               done_res;

  modport source (output valid, output value, output is_prime, output prime_count,
                  output done_res, input ready);
  modport sink (input valid, input value, input is_prime, input prime_count,
                input done_res, output ready);
endinterface

### design/lps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/lps_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per step.
module lps_mod #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         step,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         last,
  output logic         rem_zero
);

  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     rem;
  logic [W-1:0]     dvd;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       trial;
  logic [W:0]       diff;

  assign trial = {rem, dvd[W-1]};
  assign diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(W - 1);
    end else if (step) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
    end else if (step) begin
      // Keep the shifted remainder unless the divisor fits into it.
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= trial[W-1:0];
      end
      dvd <= {dvd[W-2:0], 1'b0};
    end
  end

  assign last = (cnt == '0);
  assign rem_zero = (rem == '0);

endmodule

### design/lps_seq.sv
// Microcoded sequencer: step register, control store lookup and jump logic.
module lps_seq import lps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lps_stat_t stat,
  output lps_ctrl_t ctrl
);

  lps_step_t  pc;
  lps_step_t  pc_next;
  lps_uword_t uw;
  logic       hit;

  assign uw = ucode(pc);

  always_comb begin
    case (uw.cond)
      C_ALWAYS:      hit = 1'b1;
      C_ACCEPT:      hit = stat.accept;
      C_NOT_RESTART: hit = !stat.restart;
      C_CLR_LAST:    hit = stat.clr_last;
      C_NO_ITEM:     hit = !stat.item_live;
      C_DONE:        hit = stat.done;
      C_WALK_END:    hit = stat.walk_end;
      C_PROD_GE:     hit = stat.prod_ge;
      C_MOD_LAST:    hit = stat.mod_last;
      C_NOT_DIVIDES: hit = !stat.divides;
      C_OUT_FREE:    hit = stat.out_free;
      default:       hit = 1'b0;
    endcase
  end

  always_comb begin
    if (hit) begin
      pc_next = uw.target;
    end else if (uw.stay) begin
      pc_next = pc;
    end else begin
      pc_next = lps_step_t'(4'(pc) + 4'd1);
    end
  end

  always_comb begin
    ctrl = uw.ops;
  end

  // Reset enters the clearing pass of the composite map.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_CLR_INIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### design/lps_dpath.sv
// Sieve datapath: limit register, composite map, prime table, multiplier and result register.
module lps_dpath import lps_pkg::*; #(
  parameter int MAX_LIMIT = MAX_LIMIT_DEF,
  parameter int PRIME_SLOTS = PRIME_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lps_ctrl_t          ctrl,
  output lps_stat_t          stat,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               req_valid,
  input  logic               req_restart,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic [VALUE_W-1:0] rsp_value,
  output logic               rsp_is_prime,
  output logic [COUNT_W-1:0] rsp_prime_count,
  output logic               rsp_done_res
);

  localparam int MW = $clog2(MAX_LIMIT);
  localparam int VW = $clog2(MAX_LIMIT + 1);
  localparam int SW = $clog2(PRIME_SLOTS);
  localparam int JW = $clog2(PRIME_SLOTS + 1);
  localparam int PW = (VW > JW) ? VW : JW;
  localparam int CW = VW + LIMIT_W;
  localparam int GW = 2 * MW + LIMIT_W;

  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] lim_eff;
  logic [VW-1:0]      cur;
  logic [PW-1:0]      pcount;
  logic [MW-1:0]      held_value;
  logic               held_prime;
  logic               is_prime;
  logic               restart_q;
  logic               item_live;
  logic [JW-1:0]      j;
  logic [MW-1:0]      p;
  logic [2*MW-1:0]    prod;
  logic [MW-1:0]      clr_addr;

  logic               map_we;
  logic [MW-1:0]      map_waddr;
  logic               map_rd;
  logic               tab_we;
  logic [MW-1:0]      tab_rd;
  logic               room;
  logic               new_prime;
  logic               accept;
  logic               out_free;
  logic               mod_last;
  logic               rem_zero;
  logic [COUNT_W-1:0] count_sat;

  assign lim_eff = (32'(limit) > 32'(MAX_LIMIT)) ? LIMIT_W'(MAX_LIMIT) : limit;
  assign accept = req_valid && ctrl.req_rdy;
  assign out_free = !rsp_valid || rsp_ready;
  assign new_prime = !map_rd;
  assign room = (32'(pcount) < 32'(PRIME_SLOTS));
  assign count_sat = (32'(pcount) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(pcount);

  // The map is written by the clearing pass and by the marks of the walk.
  assign map_we = ctrl.clr_wr || ctrl.mark;
  assign map_waddr = ctrl.clr_wr ? clr_addr : prod[MW-1:0];

  lps_ram #(.WIDTH(1), .DEPTH(MAX_LIMIT)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (ctrl.mark),
    .raddr (cur[MW-1:0]),
    .rdata (map_rd)
  );

  assign tab_we = ctrl.prime_upd && new_prime && room;

  lps_ram #(.WIDTH(MW), .DEPTH(PRIME_SLOTS)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (pcount[SW-1:0]),
    .wdata (cur[MW-1:0]),
    .raddr (j[SW-1:0]),
    .rdata (tab_rd)
  );

  lps_mod #(.W(MW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.mark),
    .step     (ctrl.mod_step),
    .dividend (cur[MW-1:0]),
    .divisor  (p),
    .last     (mod_last),
    .rem_zero (rem_zero)
  );

  always_comb begin
    stat.accept = accept;
    stat.restart = restart_q;
    stat.clr_last = (clr_addr == MW'(MAX_LIMIT - 1));
    stat.item_live = item_live;
    stat.done = (CW'(cur) >= CW'(lim_eff));
    stat.walk_end = (PW'(j) >= pcount) || (32'(j) >= 32'(PRIME_SLOTS));
    stat.prod_ge = (GW'(prod) >= GW'(lim_eff));
    stat.mod_last = mod_last;
    stat.divides = rem_zero || (p == '0);
    stat.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_live <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        item_live <= 1'b1;
      end else if ((ctrl.out_res || ctrl.out_done) && out_free) begin
        item_live <= 1'b0;
      end
      if ((ctrl.out_res || ctrl.out_done) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      restart_q <= req_restart;
    end
    if (ctrl.clr_init) begin
      cur <= VW'(FIRST_VALUE);
      pcount <= '0;
      held_value <= '0;
      held_prime <= 1'b0;
      clr_addr <= '0;
    end
    if (ctrl.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
    if (ctrl.prime_upd) begin
      is_prime <= new_prime;
      j <= '0;
      if (new_prime) begin
        pcount <= pcount + 1'b1;
      end
    end
    if (ctrl.mul) begin
      p <= tab_rd;
      prod <= (2*MW)'(tab_rd) * (2*MW)'(cur[MW-1:0]);
    end
    if (ctrl.j_inc) begin
      j <= j + 1'b1;
    end
    if (ctrl.out_res && out_free) begin
      rsp_value <= VALUE_W'(cur);
      rsp_is_prime <= is_prime;
      rsp_prime_count <= count_sat;
      rsp_done_res <= 1'b0;
      held_value <= cur[MW-1:0];
      held_prime <= is_prime;
      cur <= cur + 1'b1;
    end
    // A finished run repeats the last real result and changes nothing.
    if (ctrl.out_done && out_free) begin
      rsp_value <= VALUE_W'(held_value);
      rsp_is_prime <= held_prime;
      rsp_prime_count <= count_sat;
      rsp_done_res <= 1'b1;
    end
  end

endmodule

### design/linear_prime_sieve.sv
// Top level of the linear prime sieve: sequencer, datapath and checks.
//
// Each request on req advances the sieve by one candidate value, starting at 2,
// and produces exactly one result on rsp: the value, whether it is prime, the
// running prime count, and done_res once the value has reached the limit.
// A request with restart set clears the run first and then handles value 2.
// The limit register is written through cfg_we/cfg_wdata while no request is
// in flight, a rule for the user that the block itself does not enforce; it
// takes effect from the next request. For each composite it marks, the walk
// runs the bit-serial remainder unit over the MW = log2(MAX_LIMIT) bits of
// the value, 18 by default.
// After reset, and on every restart request, a clearing pass sweeps the
// composite map one entry per cycle while req.ready stays low; the limit
// returns to 250010 at reset.
// Results sit in an output register: a stalled receiver holds the next
// request's result back, though that request itself is already accepted.
module linear_prime_sieve import lps_pkg::*; #(
  parameter int MAX_LIMIT = MAX_LIMIT_DEF,
  parameter int PRIME_SLOTS = PRIME_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  lps_req_if.sink            req,
  lps_rsp_if.source          rsp
);

  lps_ctrl_t ctrl;
  lps_stat_t stat;

  lps_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  lps_dpath #(.MAX_LIMIT(MAX_LIMIT), .PRIME_SLOTS(PRIME_SLOTS)) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .req_valid       (req.valid),
    .req_restart     (req.restart),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_value       (rsp.value),
    .rsp_is_prime    (rsp.is_prime),
    .rsp_prime_count (rsp.prime_count),
    .rsp_done_res    (rsp.done_res)
  );

  assign req.ready = ctrl.req_rdy;

  // A new request is only taken once the previous one has its result.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !stat.item_live)
    else $error("request accepted while an earlier one is still in work");

  // Marks are only written for products below the limit.
  a_mark_below: assert property (@(posedge clk) disable iff (rst)
    ctrl.mark |-> !stat.prod_ge)
    else $error("composite mark at or beyond the limit");

  // The map write port and the result register each have one user per step.
  a_excl_ops: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.clr_wr, ctrl.mark, ctrl.out_res, ctrl.out_done}))
    else $error("conflicting operations in one control word");

  // Accepting a request always leaves the wait step.
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("sequencer stayed idle after accepting a request");

endmodule
